// ===== design/gvfm_pkg.sv =====
package gvfm_pkg;

  localparam int MAX_DIM_DEF = 32;
  localparam int NUM_DIRS    = 6;
  localparam int QUAD_VERTS  = 4;

  // input kinds
  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_SCAN  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_SIZE_X = 2'd0;
  localparam logic [1:0] CFG_SIZE_Y = 2'd1;
  localparam logic [1:0] CFG_SIZE_Z = 2'd2;

  // directions
  localparam logic [2:0] DIR_BOTTOM = 3'd0;
  localparam logic [2:0] DIR_TOP    = 3'd1;
  localparam logic [2:0] DIR_LEFT   = 3'd2;
  localparam logic [2:0] DIR_RIGHT  = 3'd3;
  localparam logic [2:0] DIR_BACK   = 3'd4;
  localparam logic [2:0] DIR_FRONT  = 3'd5;

  // axes
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [4:0] voxel_x;
    logic [4:0] voxel_y;
    logic [4:0] voxel_z;
    logic       occupied;
  } in_t;

  typedef struct packed {
    logic        face_valid;
    logic [2:0]  direction;
    logic [5:0]  corner_a_x;
    logic [5:0]  corner_a_y;
    logic [5:0]  corner_a_z;
    logic [5:0]  corner_b_x;
    logic [5:0]  corner_b_y;
    logic [5:0]  corner_b_z;
    logic [19:0] first_vertex;
    logic        last;
    logic        scan_done;
  } out_t;

  function automatic logic [1:0] ax_first(input logic [2:0] d);
    return (d == DIR_BOTTOM || d == DIR_TOP) ? AXIS_X : AXIS_Y;
  endfunction

  function automatic logic [1:0] ax_second(input logic [2:0] d);
    return (d == DIR_BACK || d == DIR_FRONT) ? AXIS_X : AXIS_Z;
  endfunction

  function automatic logic [1:0] ax_normal(input logic [2:0] d);
    logic [1:0] r;
    r = AXIS_Z;
    if (d == DIR_BOTTOM || d == DIR_TOP) r = AXIS_Y;
    else if (d == DIR_LEFT || d == DIR_RIGHT) r = AXIS_X;
    return r;
  endfunction

  function automatic logic swap_second(input logic [2:0] d);
    return (d == DIR_TOP || d == DIR_RIGHT || d == DIR_BACK);
  endfunction

endpackage

// ===== design/greedy_voxel_face_mesher_unit.sv =====
// greedy voxel face mesher: holds a binary volume of up to MAX_DIM cubed voxels in a
// synchronous voxel memory (two read ports) and a six-bit visited memory, and meshes it
// into quads one scan beat at a time. a write beat stores one voxel. a start
// beat clears the scan position, the vertex counter and every visited entry through a
// clearing pass over all MAX_DIM**3 entries (32768 at the default), also run once after
// reset; no input beat is taken during the pass, config writes are. a scan beat visits the
// next cell and, for each of the six directions, grows a quad: every probed cell is
// addressed in ST_ISSUE and its registered read is judged in ST_EVAL, and each accepted row
// along the second axis then has its visited marks set cell by cell by a read-modify-write
// (ST_MARK_RD, then ST_MARK_WR). the results of one beat leave through a one-deep holding
// slot and an output register, so the next beat is taken while the last result still waits.
module greedy_voxel_face_mesher_unit #(
  parameter int MAX_DIM = gvfm_pkg::MAX_DIM_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  gvfm_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output gvfm_pkg::out_t out_data_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [1:0]     cfg_index_i,
  input  logic [5:0]     cfg_data_i
);

  localparam int CELLS = MAX_DIM * MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(CELLS);
  localparam int IW    = $clog2(MAX_DIM);
  localparam int CW    = IW + 1;   // holds one past the last cell
  localparam int ND    = gvfm_pkg::NUM_DIRS;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_ISSUE, ST_EVAL, ST_MARK_RD, ST_MARK_WR,
    ST_EMIT, ST_NEXT, ST_FIN
  } state_e;

  typedef enum logic [1:0] {
    MD_SEED, MD_RUN, MD_ROW
  } mode_e;

  state_e       state_q;
  mode_e        mode_q;
  logic [5:0]   size_q [3];
  logic [IW-1:0] scan_q [3];
  logic [19:0]  vc_q;
  logic [AW-1:0] clr_q;
  logic [2:0]   d_q;
  logic [CW-1:0] c_q [3];
  logic [CW-1:0] p_q [3];
  logic [CW-1:0] e1_q, e2_q, i_q;
  logic         done_q;
  gvfm_pkg::out_t held_q, out_q;
  logic         held_v_q, out_v_q;

  logic [CW-1:0] eff [3];
  logic [CW-1:0] n_c [3];
  logic [1:0]   a1, a2, an;
  logic         plus, p_in, n_in, exposed, slot_free, out_load;
  logic [CW-1:0] ca [3];
  logic [CW-1:0] cb [3];
  gvfm_pkg::out_t q_res, empty_res, held_last;
  logic         vox_rd_a, vox_rd_b;
  logic [ND-1:0] vis_rd, vis_wdata;
  logic         vis_we, vox_we, in_fire, wr_ok;
  logic [AW-1:0] vis_addr;
  logic         wrap_x, wrap_z, wrap_y;

  function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] x, input logic [CW-1:0] y,
                                              input logic [CW-1:0] z);
    return AW'((int'(y) * MAX_DIM + int'(z)) * MAX_DIM + int'(x));
  endfunction

  // effective sizes: zero acts as one, above MAX_DIM clamps
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (size_q[k] == 6'd0) eff[k] = CW'(1);
      else if (int'(size_q[k]) > MAX_DIM) eff[k] = CW'(MAX_DIM);
      else eff[k] = CW'(size_q[k]);
    end
  end

  assign a1   = gvfm_pkg::ax_first(d_q);
  assign a2   = gvfm_pkg::ax_second(d_q);
  assign an   = gvfm_pkg::ax_normal(d_q);
  assign plus = d_q[0];

  // neighbor of the probed cell across the face
  always_comb begin
    for (int k = 0; k < 3; k++) n_c[k] = p_q[k];
    n_c[an] = plus ? p_q[an] + CW'(1) : p_q[an] - CW'(1);
  end

  assign p_in = (p_q[0] < eff[0]) && (p_q[1] < eff[1]) && (p_q[2] < eff[2]);
  assign n_in = (n_c[0] < eff[0]) && (n_c[1] < eff[1]) && (n_c[2] < eff[2]) &&
                !(!plus && p_q[an] == '0);
  assign exposed = p_in && !vis_rd[d_q] && vox_rd_a && !(n_in && vox_rd_b);

  assign in_fire   = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign slot_free = !out_v_q || out_ready_i;
  // output register takes a new beat this cycle
  assign out_load  = slot_free && ((state_q == ST_EMIT && held_v_q) || state_q == ST_FIN);

  assign wr_ok  = (int'(in_data_i.voxel_x) < MAX_DIM) && (int'(in_data_i.voxel_y) < MAX_DIM) &&
                  (int'(in_data_i.voxel_z) < MAX_DIM);
  assign vox_we = in_fire && (in_data_i.kind == gvfm_pkg::KIND_WRITE) && wr_ok;

  // visited port: clear sweep, mark on a seed or run hit, row mark write
  always_comb begin
    vis_we    = 1'b0;
    vis_addr  = cell_addr(p_q[0], p_q[1], p_q[2]);
    vis_wdata = vis_rd | (ND'(1) << d_q);
    case (state_q)
      ST_CLEAR: begin
        vis_we    = 1'b1;
        vis_addr  = clr_q;
        vis_wdata = '0;
      end
      ST_EVAL:    vis_we = exposed && (mode_q != MD_ROW);
      ST_MARK_WR: vis_we = 1'b1;
      default:    vis_we = 1'b0;
    endcase
  end

  gvfm_store #(.MAX_DIM(MAX_DIM)) u_store (
    .clk_i         (clk_i),
    .vox_we_i      (vox_we),
    .vox_waddr_i   (cell_addr(CW'(in_data_i.voxel_x), CW'(in_data_i.voxel_y),
                              CW'(in_data_i.voxel_z))),
    .vox_wdata_i   (in_data_i.occupied),
    .vox_raddr_a_i (cell_addr(p_q[0], p_q[1], p_q[2])),
    .vox_raddr_b_i (cell_addr(n_c[0], n_c[1], n_c[2])),
    .vox_rdata_a_o (vox_rd_a),
    .vox_rdata_b_o (vox_rd_b),
    .vis_we_i      (vis_we),
    .vis_addr_i    (vis_addr),
    .vis_wdata_i   (vis_wdata),
    .vis_rdata_o   (vis_rd)
  );

  // quad corners from the grown extents
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ca[k] = '0;
      cb[k] = '0;
    end
    ca[an] = c_q[an] + CW'(plus);
    cb[an] = c_q[an] + CW'(plus);
    ca[a1] = c_q[a1];
    cb[a1] = e1_q;
    ca[a2] = gvfm_pkg::swap_second(d_q) ? e2_q : c_q[a2];
    cb[a2] = gvfm_pkg::swap_second(d_q) ? c_q[a2] : e2_q;
    q_res              = '0;
    q_res.face_valid   = 1'b1;
    q_res.direction    = d_q;
    q_res.corner_a_x   = 6'(ca[0]);
    q_res.corner_a_y   = 6'(ca[1]);
    q_res.corner_a_z   = 6'(ca[2]);
    q_res.corner_b_x   = 6'(cb[0]);
    q_res.corner_b_y   = 6'(cb[1]);
    q_res.corner_b_z   = 6'(cb[2]);
    q_res.first_vertex = vc_q;
    q_res.scan_done    = done_q;
    empty_res           = '0;
    empty_res.last      = 1'b1;
    empty_res.scan_done = done_q;
    // the final quad of a step carries last
    held_last      = held_q;
    held_last.last = 1'b1;
  end

  // scan position steps x fastest, then z, then y
  assign wrap_x = ({1'b0, scan_q[0]} + CW'(1)) >= eff[0];
  assign wrap_z = ({1'b0, scan_q[2]} + CW'(1)) >= eff[2];
  assign wrap_y = ({1'b0, scan_q[1]} + CW'(1)) >= eff[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      mode_q   <= MD_SEED;
      for (int k = 0; k < 3; k++) begin
        size_q[k] <= 6'd32;
        scan_q[k] <= '0;
      end
      vc_q     <= '0;
      clr_q    <= '0;
      d_q      <= gvfm_pkg::DIR_BOTTOM;
      done_q   <= 1'b0;
      held_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          gvfm_pkg::CFG_SIZE_X: size_q[0] <= cfg_data_i;
          gvfm_pkg::CFG_SIZE_Y: size_q[1] <= cfg_data_i;
          gvfm_pkg::CFG_SIZE_Z: size_q[2] <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_v_q && out_ready_i && !out_load) out_v_q <= 1'b0;

      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == AW'(CELLS - 1)) state_q <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_fire) begin
            case (in_data_i.kind)
              gvfm_pkg::KIND_START: begin
                for (int k = 0; k < 3; k++) scan_q[k] <= '0;
                vc_q    <= '0;
                clr_q   <= '0;
                state_q <= ST_CLEAR;
              end
              gvfm_pkg::KIND_SCAN: begin
                for (int k = 0; k < 3; k++) begin
                  c_q[k] <= {1'b0, scan_q[k]};
                  p_q[k] <= {1'b0, scan_q[k]};
                end
                done_q <= 1'b0;
                if (!wrap_x) begin
                  scan_q[0] <= scan_q[0] + IW'(1);
                end else begin
                  scan_q[0] <= '0;
                  if (!wrap_z) begin
                    scan_q[2] <= scan_q[2] + IW'(1);
                  end else begin
                    scan_q[2] <= '0;
                    if (!wrap_y) begin
                      scan_q[1] <= scan_q[1] + IW'(1);
                    end else begin
                      scan_q[1] <= '0;
                      done_q    <= 1'b1;
                    end
                  end
                end
                d_q     <= gvfm_pkg::DIR_BOTTOM;
                mode_q  <= MD_SEED;
                state_q <= ST_ISSUE;
              end
              default: ;
            endcase
          end
        end
        ST_ISSUE: state_q <= ST_EVAL;
        ST_EVAL: begin
          case (mode_q)
            MD_SEED: begin
              if (exposed) begin
                e1_q       <= c_q[a1] + CW'(1);
                p_q[a1]    <= c_q[a1] + CW'(1);
                mode_q     <= MD_RUN;
                state_q    <= ST_ISSUE;
              end else begin
                state_q <= ST_NEXT;
              end
            end
            MD_RUN: begin
              if (exposed) begin
                e1_q    <= e1_q + CW'(1);
                p_q[a1] <= e1_q + CW'(1);
              end else begin
                e2_q    <= c_q[a2] + CW'(1);
                i_q     <= c_q[a1];
                p_q[a1] <= c_q[a1];
                p_q[a2] <= c_q[a2] + CW'(1);
                mode_q  <= MD_ROW;
              end
              state_q <= ST_ISSUE;
            end
            default: begin
              if (!exposed) begin
                state_q <= ST_EMIT;
              end else if (i_q + CW'(1) == e1_q) begin
                // whole row exposed: mark it
                i_q     <= c_q[a1];
                p_q[a1] <= c_q[a1];
                state_q <= ST_MARK_RD;
              end else begin
                i_q     <= i_q + CW'(1);
                p_q[a1] <= i_q + CW'(1);
                state_q <= ST_ISSUE;
              end
            end
          endcase
        end
        ST_MARK_RD: state_q <= ST_MARK_WR;
        ST_MARK_WR: begin
          if (i_q + CW'(1) == e1_q) begin
            e2_q    <= e2_q + CW'(1);
            i_q     <= c_q[a1];
            p_q[a1] <= c_q[a1];
            p_q[a2] <= e2_q + CW'(1);
            state_q <= ST_ISSUE;
          end else begin
            i_q     <= i_q + CW'(1);
            p_q[a1] <= i_q + CW'(1);
            state_q <= ST_MARK_RD;
          end
        end
        ST_EMIT: begin
          // the held quad is not last, since another one follows
          if (!held_v_q || slot_free) begin
            if (held_v_q) begin
              out_q   <= held_q;
              out_v_q <= 1'b1;
            end
            held_q   <= q_res;
            held_v_q <= 1'b1;
            vc_q     <= vc_q + 20'(gvfm_pkg::QUAD_VERTS);
            state_q  <= ST_NEXT;
          end
        end
        ST_NEXT: begin
          if (d_q == gvfm_pkg::DIR_FRONT) begin
            state_q <= ST_FIN;
          end else begin
            d_q     <= d_q + 3'd1;
            for (int k = 0; k < 3; k++) p_q[k] <= c_q[k];
            mode_q  <= MD_SEED;
            state_q <= ST_ISSUE;
          end
        end
        ST_FIN: begin
          if (slot_free) begin
            if (held_v_q) begin
              out_q <= held_last;
            end else begin
              out_q <= empty_res;
            end
            out_v_q  <= 1'b1;
            held_v_q <= 1'b0;
            state_q  <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

// ===== design/gvfm_store.sv =====
module gvfm_store #(
  parameter int MAX_DIM = gvfm_pkg::MAX_DIM_DEF,
  localparam int CELLS  = MAX_DIM * MAX_DIM * MAX_DIM,
  localparam int AW     = $clog2(CELLS)
) (
  input  logic                          clk_i,
  input  logic                          vox_we_i,
  input  logic [AW-1:0]                 vox_waddr_i,
  input  logic                          vox_wdata_i,
  input  logic [AW-1:0]                 vox_raddr_a_i,
  input  logic [AW-1:0]                 vox_raddr_b_i,
  output logic                          vox_rdata_a_o,
  output logic                          vox_rdata_b_o,
  input  logic                          vis_we_i,
  input  logic [AW-1:0]                 vis_addr_i,
  input  logic [gvfm_pkg::NUM_DIRS-1:0] vis_wdata_i,
  output logic [gvfm_pkg::NUM_DIRS-1:0] vis_rdata_o
);

  logic                          vox_mem [CELLS];
  logic [gvfm_pkg::NUM_DIRS-1:0] vis_mem [CELLS];

  always_ff @(posedge clk_i) begin
    if (vox_we_i) begin
      vox_mem[vox_waddr_i] <= vox_wdata_i;
    end
    vox_rdata_a_o <= vox_mem[vox_raddr_a_i];
    vox_rdata_b_o <= vox_mem[vox_raddr_b_i];
  end

  always_ff @(posedge clk_i) begin
    if (vis_we_i) begin
      vis_mem[vis_addr_i] <= vis_wdata_i;
    end
    vis_rdata_o <= vis_mem[vis_addr_i];
  end

endmodule
